// ===== design/cas_pkg.sv =====
`default_nettype none

package cas_pkg;

   localparam logic [3:0] OP_M  = 4'd0;
   localparam logic [3:0] OP_I  = 4'd1;
   localparam logic [3:0] OP_D  = 4'd2;
   localparam logic [3:0] OP_S  = 4'd4;
   localparam logic [3:0] OP_H  = 4'd5;
   localparam logic [3:0] OP_EQ = 4'd7;
   localparam logic [3:0] OP_X  = 4'd8;

   localparam logic [15:0] THRESHOLD_RESET = 16'd85;
   localparam int unsigned REVERSE_BIT     = 4;

   localparam int unsigned REQ_DATA_W = 96;
   localparam int unsigned RSP_DATA_W = 216;

   typedef enum logic [2:0] {
      KIND_NONE     = 3'd0,
      KIND_MATCH    = 3'd1,
      KIND_MISMATCH = 3'd2,
      KIND_INSERT   = 3'd3,
      KIND_DELETE   = 3'd4,
      KIND_CLIP     = 3'd5
   } op_kind_type;

   typedef struct packed {
      logic        first;
      logic        last;
      op_kind_type kind;
      logic        longrun;
      logic [27:0] length;
      logic [30:0] ref_start;
      logic [15:0] ref_index;
      logic        reverse;
   } queue_entry_type;

   typedef struct packed {
      logic [31:0] query_begin;
      logic [31:0] query_end;
      logic [31:0] ref_begin;
      logic [31:0] ref_end;
      logic [31:0] match_bases;
      logic [31:0] edit_bases;
      logic        indel_split;
      logic        reverse_strand;
      logic [15:0] seg_ref_index;
   } segment_type;

endpackage

`default_nettype wire

// ===== design/cas_front.sv =====
`default_nettype none

module cas_front (
   input  wire logic [cas_pkg::REQ_DATA_W-1:0] req_tdata,
   input  wire logic                           req_tuser,
   input  wire logic                           req_tlast,
   input  wire logic [15:0]                    threshold,
   output cas_pkg::queue_entry_type            entry
);

   logic [3:0]  op_code;
   logic [27:0] op_length;
   logic [11:0] align_flags;

   assign op_code     = req_tdata[3:0];
   assign op_length   = req_tdata[31:4];
   assign align_flags = req_tdata[90:79];

   always_comb begin
      entry.first     = req_tuser;
      entry.last      = req_tlast;
      entry.length    = op_length;
      entry.ref_start = req_tdata[62:32];
      entry.ref_index = req_tdata[78:63];
      entry.reverse   = align_flags[cas_pkg::REVERSE_BIT];
      entry.longrun   = op_length > {12'd0, threshold};
      case (op_code)
         cas_pkg::OP_M, cas_pkg::OP_EQ: entry.kind = cas_pkg::KIND_MATCH;
         cas_pkg::OP_X:                 entry.kind = cas_pkg::KIND_MISMATCH;
         cas_pkg::OP_I:                 entry.kind = cas_pkg::KIND_INSERT;
         cas_pkg::OP_D:                 entry.kind = cas_pkg::KIND_DELETE;
         cas_pkg::OP_S, cas_pkg::OP_H:  entry.kind = cas_pkg::KIND_CLIP;
         default:                       entry.kind = cas_pkg::KIND_NONE;
      endcase
   end

endmodule

`default_nettype wire

// ===== design/cas_queue.sv =====
`default_nettype none

module cas_queue #(
   parameter int unsigned DEPTH = 2
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      push,
   input  wire cas_pkg::queue_entry_type  push_entry,
   output logic                           full,
   input  wire logic                      pop,
   output cas_pkg::queue_entry_type       head,
   output logic                           head_valid
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

   cas_pkg::queue_entry_type entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full       = count_ff == CNT_W'(DEPTH);
   assign head_valid = count_ff != '0;
   assign head       = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

// ===== design/cas_back.sv =====
`default_nettype none

module cas_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire cas_pkg::queue_entry_type entry,
   input  wire logic                entry_valid,
   output logic                     pop,
   output logic                     seg_valid,
   input  wire logic                seg_ready,
   output cas_pkg::segment_type     segment
);

   logic [31:0] query_pos_ff, query_pos_in;
   logic [31:0] ref_pos_ff, ref_pos_in;
   logic [31:0] match_count_ff, match_count_in;
   logic [31:0] edit_count_ff, edit_count_in;
   logic [31:0] open_qb_ff, open_qb_in;
   logic [31:0] open_rb_ff, open_rb_in;
   logic        open_indel_ff, open_indel_in;
   logic [15:0] held_index_ff, held_index_in;
   logic        held_reverse_ff, held_reverse_in;
   logic        seg_valid_ff, seg_valid_in;
   cas_pkg::segment_type segment_ff, segment_in;

   logic [31:0] q_cur, r_cur, mc_cur, ec_cur, qb_cur, rb_cur;
   logic        flag_cur;
   logic [31:0] len32, q_add, r_add, mc_add, ec_add, r_inc, q_inc;
   logic        emit;
   logic        stall;

   assign stall     = seg_valid_ff && !seg_ready;
   assign pop       = entry_valid && !stall;
   assign seg_valid = seg_valid_ff;
   assign segment   = segment_ff;

   always_comb begin
      if (entry.first) begin
         q_cur           = '0;
         r_cur           = {1'b0, entry.ref_start};
         mc_cur          = '0;
         ec_cur          = '0;
         qb_cur          = '0;
         rb_cur          = {1'b0, entry.ref_start};
         flag_cur        = 1'b0;
         held_index_in   = entry.ref_index;
         held_reverse_in = entry.reverse;
      end else begin
         q_cur           = query_pos_ff;
         r_cur           = ref_pos_ff;
         mc_cur          = match_count_ff;
         ec_cur          = edit_count_ff;
         qb_cur          = open_qb_ff;
         rb_cur          = open_rb_ff;
         flag_cur        = open_indel_ff;
         held_index_in   = held_index_ff;
         held_reverse_in = held_reverse_ff;
      end

      len32  = 32'(entry.length);
      q_add  = q_cur + len32;
      r_add  = r_cur + len32;
      mc_add = mc_cur + len32;
      ec_add = ec_cur + len32;
      r_inc  = r_cur + 32'd1;
      q_inc  = q_cur + 32'd1;

      query_pos_in   = q_cur;
      ref_pos_in     = r_cur;
      match_count_in = mc_cur;
      edit_count_in  = ec_cur;
      open_qb_in     = qb_cur;
      open_rb_in     = rb_cur;
      open_indel_in  = flag_cur;
      emit           = 1'b0;

      segment_in.query_begin    = qb_cur;
      segment_in.query_end      = q_cur;
      segment_in.ref_begin      = rb_cur;
      segment_in.ref_end        = r_cur;
      segment_in.match_bases    = mc_cur;
      segment_in.edit_bases     = ec_cur;
      segment_in.indel_split    = flag_cur;
      segment_in.reverse_strand = held_reverse_in;
      segment_in.seg_ref_index  = held_index_in;

      if (entry.last) begin
         emit           = 1'b1;
         match_count_in = '0;
         edit_count_in  = '0;
         query_pos_in   = q_add;
         if (entry.kind != cas_pkg::KIND_CLIP) begin
            ref_pos_in             = r_add;
            segment_in.query_end   = q_add;
            segment_in.ref_end     = r_add;
            segment_in.match_bases = mc_add;
         end
      end else begin
         case (entry.kind)
            cas_pkg::KIND_MATCH: begin
               query_pos_in   = q_add;
               ref_pos_in     = r_add;
               match_count_in = mc_add;
            end
            cas_pkg::KIND_MISMATCH: begin
               query_pos_in  = q_add;
               ref_pos_in    = r_add;
               edit_count_in = ec_add;
            end
            cas_pkg::KIND_INSERT: begin
               query_pos_in  = q_add;
               edit_count_in = ec_add;
               if (entry.longrun) begin
                  emit                   = 1'b1;
                  segment_in.indel_split = 1'b1;
                  match_count_in         = '0;
                  edit_count_in          = '0;
                  open_qb_in             = q_add;
                  open_rb_in             = r_inc;
                  open_indel_in          = 1'b1;
               end
            end
            cas_pkg::KIND_DELETE: begin
               ref_pos_in    = r_add;
               edit_count_in = ec_add;
               if (entry.longrun) begin
                  emit                   = 1'b1;
                  segment_in.indel_split = 1'b1;
                  match_count_in         = '0;
                  edit_count_in          = '0;
                  open_qb_in             = q_inc;
                  open_rb_in             = r_add;
                  open_indel_in          = 1'b1;
               end
            end
            cas_pkg::KIND_CLIP: begin
               query_pos_in  = q_add;
               open_qb_in    = q_add;
               open_indel_in = 1'b0;
               if (q_cur == '0) begin
                  open_rb_in = r_cur;
               end else begin
                  emit           = 1'b1;
                  match_count_in = '0;
                  edit_count_in  = '0;
                  open_rb_in     = r_inc;
               end
            end
            default: begin
            end
         endcase
      end

      if (pop && emit) begin
         seg_valid_in = 1'b1;
      end else if (seg_ready) begin
         seg_valid_in = 1'b0;
      end else begin
         seg_valid_in = seg_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         query_pos_ff    <= '0;
         ref_pos_ff      <= '0;
         match_count_ff  <= '0;
         edit_count_ff   <= '0;
         open_qb_ff      <= '0;
         open_rb_ff      <= '0;
         open_indel_ff   <= 1'b0;
         held_index_ff   <= '0;
         held_reverse_ff <= 1'b0;
         seg_valid_ff    <= 1'b0;
      end else begin
         seg_valid_ff <= seg_valid_in;
         if (pop) begin
            query_pos_ff    <= query_pos_in;
            ref_pos_ff      <= ref_pos_in;
            match_count_ff  <= match_count_in;
            edit_count_ff   <= edit_count_in;
            open_qb_ff      <= open_qb_in;
            open_rb_ff      <= open_rb_in;
            open_indel_ff   <= open_indel_in;
            held_index_ff   <= held_index_in;
            held_reverse_ff <= held_reverse_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop && emit) begin
         segment_ff <= segment_in;
      end
   end

   a_no_pop_on_stall: assert property (@(posedge clock) disable iff (reset)
      (seg_valid_ff && !seg_ready) |-> !pop)
      else $error("entry retired while result held");

   a_last_clears_counts: assert property (@(posedge clock) disable iff (reset)
      (pop && entry.last) |=> (match_count_ff == '0 && edit_count_ff == '0))
      else $error("counts not cleared after last operation");

   a_long_indel_marks: assert property (@(posedge clock) disable iff (reset)
      (pop && !entry.last && entry.longrun &&
       (entry.kind == cas_pkg::KIND_INSERT || entry.kind == cas_pkg::KIND_DELETE))
      |=> (open_indel_ff && seg_valid_ff && segment_ff.indel_split))
      else $error("long indel did not split the segment");

   a_last_emits: assert property (@(posedge clock) disable iff (reset)
      (pop && entry.last) |=> seg_valid_ff)
      else $error("last operation gave no segment");

endmodule

`default_nettype wire

// ===== design/cigar_alignment_segmenter_unit.sv =====
// A closing op passes through the op queue; its segment is then registered onto rsp_.
// Throughput: one CIGAR op per cycle; the back end retires one queued op per cycle
// while no segment waits on rsp_ with rsp_tready low, updating positions and counts.
// req_tready drops only when the op queue is full; it fills while rsp_ is stalled.
// Reset: synchronous, active high; clears positions, counts, queue and output valid,
// and sets the indel split threshold to 85.
`default_nettype none

module cigar_alignment_segmenter_unit #(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  wire logic                           clock,
   input  wire logic                           reset,

   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   // op_code[3:0], op_length[31:4], ref_start[62:32], ref_index[78:63],
   // align_flags[90:79], zero [95:91]
   input  wire logic [cas_pkg::REQ_DATA_W-1:0] req_tdata,
   // first_op
   input  wire logic                           req_tuser,
   input  wire logic                           req_tlast,

   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   // query_begin[31:0], query_end[63:32], ref_begin[95:64], ref_end[127:96],
   // match_bases[159:128], edit_bases[191:160], reverse_strand[192],
   // seg_ref_index[208:193], zero [215:209]
   output logic [cas_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // indel_split
   output logic                                rsp_tuser,

   input  wire logic                           csr_psel,
   input  wire logic                           csr_penable,
   input  wire logic                           csr_pwrite,
   input  wire logic [2:0]                     csr_paddr,
   input  wire logic [31:0]                    csr_pwdata,
   output logic [31:0]                         csr_prdata,
   output logic                                csr_pready
);

   logic [15:0] threshold_ff, threshold_in;
   logic        queue_full;
   logic        queue_push;
   logic        queue_pop;
   logic        head_valid;
   cas_pkg::queue_entry_type front_entry;
   cas_pkg::queue_entry_type head_entry;
   cas_pkg::segment_type     segment;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == 1'b0) ? {16'd0, threshold_ff} : 32'd0;

   always_comb begin
      threshold_in = threshold_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_paddr[2] == 1'b0) begin
         threshold_in = csr_pwdata[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= cas_pkg::THRESHOLD_RESET;
      end else begin
         threshold_ff <= threshold_in;
      end
   end

   assign req_tready = !queue_full;
   assign queue_push = req_tvalid && !queue_full;

   cas_front u_front (
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .req_tlast (req_tlast),
      .threshold (threshold_ff),
      .entry     (front_entry)
   );

   cas_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (queue_push),
      .push_entry (front_entry),
      .full       (queue_full),
      .pop        (queue_pop),
      .head       (head_entry),
      .head_valid (head_valid)
   );

   cas_back u_back (
      .clock       (clock),
      .reset       (reset),
      .entry       (head_entry),
      .entry_valid (head_valid),
      .pop         (queue_pop),
      .seg_valid   (rsp_tvalid),
      .seg_ready   (rsp_tready),
      .segment     (segment)
   );

   assign rsp_tuser = segment.indel_split;
   assign rsp_tdata = {7'd0, segment.seg_ref_index, segment.reverse_strand,
                       segment.edit_bases, segment.match_bases,
                       segment.ref_end, segment.ref_begin,
                       segment.query_end, segment.query_begin};

endmodule

`default_nettype wire

// ===== dv/cigar_alignment_segmenter_unit_tb.sv =====
`default_nettype none

module cigar_alignment_segmenter_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [3:0] OP_N = 4'd3;
   localparam logic [3:0] OP_P = 4'd6;
   localparam logic [3:0] OP_CODE_MAX = 4'd15;
   localparam logic [2:0] THRESHOLD_ADDR = 3'd0;
   localparam int CYCLE_LIMIT = 200000;
   localparam int ITEMS_PER_PHASE = 190;
   localparam int HOLD_OFF_CYCLES = 80;
   localparam int HOLD_OFF_AFTER = 120;
   localparam int DRAIN_CYCLES = 8;

   class segment_scoreboard;
      logic [15:0] threshold;
      logic [31:0] qpos, rpos, match_sum, edits, seg_qbegin, seg_rbegin;
      logic        split_mark, rev;
      logic [15:0] ridx;
      cas_pkg::segment_type expected_q[$];
      int          mismatches;

      function new();
         threshold = cas_pkg::THRESHOLD_RESET;
         qpos = 0; rpos = 0; match_sum = 0; edits = 0;
         seg_qbegin = 0; seg_rbegin = 0; split_mark = 0; rev = 0; ridx = 0;
         mismatches = 0;
      endfunction

      function void set_threshold(logic [15:0] value);
         threshold = value;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function void close_segment(logic [31:0] qend, logic [31:0] rend, logic [31:0] ed);
         cas_pkg::segment_type s;
         s.query_begin    = seg_qbegin;
         s.query_end      = qend;
         s.ref_begin      = seg_rbegin;
         s.ref_end        = rend;
         s.match_bases    = match_sum;
         s.edit_bases     = ed;
         s.indel_split    = split_mark;
         s.reverse_strand = rev;
         s.seg_ref_index  = ridx;
         expected_q.insert(expected_q.size(), s);
         match_sum = 0;
         edits = 0;
      endfunction

      function void note_op(logic first, logic last, logic [3:0] code, logic [27:0] len,
                            logic [30:0] rs, logic [15:0] ri, logic [11:0] flags);
         logic [31:0] run, qstart, rstart, prior;
         logic        clip, longrun;
         run = {4'd0, len};
         clip = (code == cas_pkg::OP_S) || (code == cas_pkg::OP_H);
         longrun = run > {16'd0, threshold};
         if (first) begin
            qpos = 0;
            rpos = {1'b0, rs};
            match_sum = 0;
            edits = 0;
            seg_qbegin = 0;
            seg_rbegin = {1'b0, rs};
            split_mark = 0;
            ridx = ri;
            rev = flags[cas_pkg::REVERSE_BIT];
         end
         if (last) begin
            if (clip) begin
               close_segment(qpos, rpos, edits);
               qpos += run;
            end else begin
               qpos += run;
               rpos += run;
               match_sum += run;
               close_segment(qpos, rpos, edits);
            end
            return;
         end
         if (code == cas_pkg::OP_M || code == cas_pkg::OP_EQ) begin
            qpos += run;
            rpos += run;
            match_sum += run;
         end else if (code == cas_pkg::OP_X) begin
            qpos += run;
            rpos += run;
            edits += run;
         end else if (code == cas_pkg::OP_I) begin
            prior = edits;
            qstart = qpos;
            qpos += run;
            edits += run;
            if (longrun) begin
               split_mark = 1'b1;
               close_segment(qstart, rpos, prior);
               seg_qbegin = qpos;
               seg_rbegin = rpos + 32'd1;
            end
         end else if (code == cas_pkg::OP_D) begin
            prior = edits;
            rstart = rpos;
            rpos += run;
            edits += run;
            if (longrun) begin
               split_mark = 1'b1;
               close_segment(qpos, rstart, prior);
               seg_qbegin = qpos + 32'd1;
               seg_rbegin = rpos;
            end
         end else if (clip) begin
            qstart = qpos;
            qpos += run;
            if (qstart == 0) begin
               seg_qbegin = qpos;
               seg_rbegin = rpos;
               split_mark = 1'b0;
            end else begin
               close_segment(qstart, rpos, edits);
               seg_qbegin = qpos;
               seg_rbegin = rpos + 32'd1;
               split_mark = 1'b0;
            end
         end
      endfunction

      function void report(string what, logic [31:0] want, logic [31:0] seen);
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch on %s: expected %0h actual %0h", what, want, seen);
      endfunction

      function void check_segment(cas_pkg::segment_type got);
         cas_pkg::segment_type e;
         if (expected_q.size() == 0) begin
            report("unexpected segment query_begin", 32'd0, got.query_begin);
            return;
         end
         e = expected_q.pop_front();
         if (got.query_begin !== e.query_begin)
            report("query_begin", e.query_begin, got.query_begin);
         if (got.query_end !== e.query_end)
            report("query_end", e.query_end, got.query_end);
         if (got.ref_begin !== e.ref_begin)
            report("ref_begin", e.ref_begin, got.ref_begin);
         if (got.ref_end !== e.ref_end)
            report("ref_end", e.ref_end, got.ref_end);
         if (got.match_bases !== e.match_bases)
            report("match_bases", e.match_bases, got.match_bases);
         if (got.edit_bases !== e.edit_bases)
            report("edit_bases", e.edit_bases, got.edit_bases);
         if (got.indel_split !== e.indel_split)
            report("indel_split", {31'd0, e.indel_split}, {31'd0, got.indel_split});
         if (got.reverse_strand !== e.reverse_strand)
            report("reverse_strand", {31'd0, e.reverse_strand}, {31'd0, got.reverse_strand});
         if (got.seg_ref_index !== e.seg_ref_index)
            report("seg_ref_index", {16'd0, e.seg_ref_index}, {16'd0, got.seg_ref_index});
      endfunction
   endclass

   logic                           clock;
   logic                           reset = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [cas_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic                           req_tuser = 1'b0;
   logic                           req_tlast = 1'b0;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [cas_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                           rsp_tuser;
   logic                           csr_psel = 1'b0;
   logic                           csr_penable = 1'b0;
   logic                           csr_pwrite = 1'b0;
   logic [2:0]                     csr_paddr = '0;
   logic [31:0]                    csr_pwdata = '0;
   logic [31:0]                    csr_prdata;
   logic                           csr_pready;

   segment_scoreboard sb = new();
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;
   int          accepted_ops = 0;
   int          hold_left = 0;
   bit          pressure_done = 1'b0;
   int          cycle_count = 0;
   logic [15:0] cur_threshold = cas_pkg::THRESHOLD_RESET;

   cigar_alignment_segmenter_unit DUT (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // hold off the result side once for a long stretch so the op queue fills
   always @(posedge clock) begin
      if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (!pressure_done && accepted_ops >= HOLD_OFF_AFTER) begin
         hold_left <= HOLD_OFF_CYCLES;
         pressure_done <= 1'b1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      cas_pkg::segment_type got;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            sb.note_op(req_tuser, req_tlast, req_tdata[3:0], req_tdata[31:4],
                       req_tdata[62:32], req_tdata[78:63], req_tdata[90:79]);
            accepted_ops <= accepted_ops + 1;
         end
         if (rsp_tvalid && rsp_tready) begin
            got.query_begin    = rsp_tdata[31:0];
            got.query_end      = rsp_tdata[63:32];
            got.ref_begin      = rsp_tdata[95:64];
            got.ref_end        = rsp_tdata[127:96];
            got.match_bases    = rsp_tdata[159:128];
            got.edit_bases     = rsp_tdata[191:160];
            got.reverse_strand = rsp_tdata[192];
            got.seg_ref_index  = rsp_tdata[208:193];
            got.indel_split    = rsp_tuser;
            sb.check_segment(got);
         end
      end
   end

   function automatic logic [3:0] rand_code();
      int r;
      r = $urandom_range(99);
      if (r < 28) return cas_pkg::OP_M;
      if (r < 36) return cas_pkg::OP_EQ;
      if (r < 46) return cas_pkg::OP_X;
      if (r < 58) return cas_pkg::OP_I;
      if (r < 70) return cas_pkg::OP_D;
      if (r < 78) return cas_pkg::OP_S;
      if (r < 84) return cas_pkg::OP_H;
      if (r < 88) return OP_N;
      if (r < 92) return OP_P;
      return 4'($urandom_range(OP_CODE_MAX, cas_pkg::OP_X + 1));
   endfunction

   function automatic logic [27:0] rand_length();
      int r, t;
      r = $urandom_range(99);
      if (r < 60) return 28'($urandom_range(40));
      if (r < 85) begin
         t = int'(cur_threshold) + int'($urandom_range(4)) - 2;
         if (t < 0) t = 0;
         return t[27:0];
      end
      return 28'($urandom);
   endfunction

   task automatic send_op(logic first, logic last, logic [3:0] code, logic [27:0] len,
                          logic [30:0] rs, logic [15:0] ri, logic [11:0] flags);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {5'd0, flags, ri, rs, len, code};
      req_tuser <= first;
      req_tlast <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic send_record(output int count);
      int          mids;
      bit          with_first;
      logic [30:0] rs;
      logic [15:0] ri;
      logic [11:0] fl;
      mids = $urandom_range(6);
      rs = 31'($urandom);
      ri = 16'($urandom);
      fl = 12'($urandom);
      with_first = ($urandom_range(99) >= 6);
      count = 0;
      if ($urandom_range(99) < 8) begin
         send_op(with_first, 1'b1, rand_code(), rand_length(), rs, ri, fl);
         count = 1;
         return;
      end
      send_op(with_first, 1'b0, ($urandom_range(99) < 30) ? cas_pkg::OP_S : rand_code(),
              rand_length(), rs, ri, fl);
      repeat (mids)
         send_op(1'b0, 1'b0, rand_code(), rand_length(), 31'($urandom), 16'($urandom),
                 12'($urandom));
      send_op(1'b0, 1'b1, rand_code(), rand_length(), rs, ri, fl);
      count = mids + 2;
   endtask

   task automatic wait_quiet();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_threshold(logic [15:0] value);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= THRESHOLD_ADDR;
      csr_pwdata <= {16'd0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      sb.set_threshold(value);
      cur_threshold = value;
   endtask

   task automatic run_directed();
      // clip at the start, every op kind, threshold edges, full-width fields
      send_op(1'b1, 1'b0, cas_pkg::OP_S, 28'd5, 31'h7FFF_FFFF, 16'hFFFF, 12'hFFF);
      send_op(1'b0, 1'b0, cas_pkg::OP_M, 28'd0, '0, '0, '0);
      send_op(1'b0, 1'b0, cas_pkg::OP_EQ, 28'd10, '0, '0, '0);
      send_op(1'b0, 1'b0, cas_pkg::OP_X, 28'd5, '0, '0, '0);
      send_op(1'b0, 1'b0, cas_pkg::OP_I, 28'd85, '0, '0, '0);
      send_op(1'b0, 1'b0, cas_pkg::OP_I, 28'd86, '0, '0, '0);
      send_op(1'b0, 1'b0, cas_pkg::OP_D, 28'd86, '0, '0, '0);
      send_op(1'b0, 1'b0, cas_pkg::OP_D, 28'd85, '0, '0, '0);
      send_op(1'b0, 1'b0, OP_N, 28'd7, '0, '0, '0);
      send_op(1'b0, 1'b0, OP_P, 28'd7, '0, '0, '0);
      send_op(1'b0, 1'b0, OP_CODE_MAX, 28'd9, '0, '0, '0);
      send_op(1'b0, 1'b0, cas_pkg::OP_S, 28'd3, '0, '0, '0);
      send_op(1'b0, 1'b0, cas_pkg::OP_H, 28'd2, '0, '0, '0);
      send_op(1'b0, 1'b1, cas_pkg::OP_M, 28'hFFF_FFFF, '0, '0, '0);
      send_op(1'b1, 1'b0, cas_pkg::OP_H, 28'd0, 31'd0, 16'd0, 12'h010);
      send_op(1'b0, 1'b0, cas_pkg::OP_H, 28'd4, '0, '0, '0);
      send_op(1'b0, 1'b0, cas_pkg::OP_M, 28'd20, '0, '0, '0);
      send_op(1'b0, 1'b1, cas_pkg::OP_S, 28'd4, '0, '0, '0);
      send_op(1'b1, 1'b1, OP_CODE_MAX, 28'd3, 31'h2AAA_AAAA, 16'h5555, 12'h000);
      send_op(1'b0, 1'b0, cas_pkg::OP_X, 28'd6, '0, '0, '0);
      send_op(1'b0, 1'b1, cas_pkg::OP_D, 28'd3, '0, '0, '0);
      send_op(1'b1, 1'b1, cas_pkg::OP_H, 28'hFFF_FFFF, 31'h5555_5555, 16'hAAAA, 12'hFEF);
   endtask

   initial begin
      int          phase, sent, n;
      logic [15:0] phase_threshold[5];
      int          idle_pct[5];
      int          stall_pct[5];
      phase_threshold = '{cas_pkg::THRESHOLD_RESET, 16'd0, 16'hFFFF, 16'($urandom), 16'd5};
      idle_pct = '{0, 54, 0, 24, 0};
      stall_pct = '{0, 0, 54, 24, 0};
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      run_directed();
      for (phase = 0; phase < 5; phase++) begin
         wait_quiet();
         if (phase != 0) write_threshold(phase_threshold[phase]);
         send_idle_pct = idle_pct[phase];
         recv_stall_pct = stall_pct[phase];
         sent = 0;
         while (sent < ITEMS_PER_PHASE) begin
            if ($urandom_range(99) < 4) begin
               send_op(1'($urandom), 1'($urandom), 4'($urandom), rand_length(),
                       31'($urandom), 16'($urandom), 12'($urandom));
               sent++;
            end
            send_record(n);
            sent += n;
         end
      end
      wait_quiet();
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
